// ===== hdl/ibl_pkg.sv =====
// Package with the constants, command codes and cell control type of the indexed byte list.
`default_nettype none
package ibl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int CMD_W    = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND       = 3'd0,
    CMD_INSERT_AT    = 3'd1,
    CMD_REMOVE_AT    = 3'd2,
    CMD_REMOVE_FIRST = 3'd3,
    CMD_REMOVE_LAST  = 3'd4,
    CMD_READ_AT      = 3'd5
  } cmd_t;

  typedef struct packed {
    logic              acc;
    logic              ins;
    logic              rem;
    logic              rd;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] value;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/ibl_cell.sv =====
// One storage cell of the byte chain: holds a byte, shifts with its neighbors, taps for reads.
`default_nettype none
module ibl_cell (
  input  wire logic                       clk,
  input  wire ibl_pkg::cell_ctl_t         ctl,
  input  wire logic [ibl_pkg::IDX_W-1:0]  cell_index,
  input  wire logic [ibl_pkg::BYTE_W-1:0] left_data,
  input  wire logic [ibl_pkg::BYTE_W-1:0] right_data,
  output logic      [ibl_pkg::BYTE_W-1:0] data,
  output logic      [ibl_pkg::BYTE_W-1:0] tap
);

  logic [ibl_pkg::POS_W-1:0] idx;
  logic                      at_pos;
  logic                      above_pos;

  assign idx       = ibl_pkg::POS_W'(cell_index);
  assign at_pos    = (idx == ctl.pos);
  assign above_pos = (idx > ctl.pos);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (above_pos) begin
        data <= left_data;
      end else if (at_pos) begin
        data <= ctl.value;
      end
    end else if (ctl.rem) begin
      if (above_pos || at_pos) begin
        data <= right_data;
      end
    end
    if (ctl.acc) begin
      tap <= (ctl.rd && at_pos) ? data : '0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/indexed_byte_list_unit.sv =====
// Top level of the indexed byte list: command decode, cell chain, and result pipeline.
//
// Usage: commands enter on the s_ channel (command, position, element_value packed
// in s_tdata) and each produces exactly one result item on the m_ channel (ok,
// length, read_value packed in m_tdata). The bytes live in a row of cells; an
// insert shifts every cell above the position one place up at once, a remove
// shifts them one place down, so every command is done in one update of the row.
// Throughput is one item per cycle while the receiver keeps m_tready high. An
// accepted command first updates the cells and captures the read byte in the cell
// taps; the taps are then combined into the output register. Reset empties the
// list; stored bytes are not cleared and positions at or above the length are
// never read. When the receiver holds m_tready low the result stays in the output
// register, one more item can wait in the middle stage, and s_tready falls until
// space frees up.
`default_nettype none
module indexed_byte_list_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // command [2:0], position [9:3], element_value [17:10], zero [23:18]
  input  wire logic [23:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // ok [0], length [7:1], read_value [15:8]
  output logic      [15:0] m_tdata
);

  localparam int N = ibl_pkg::CAPACITY;

  logic [ibl_pkg::CMD_W-1:0]  cmd;
  logic [ibl_pkg::POS_W-1:0]  pos;
  logic [ibl_pkg::BYTE_W-1:0] value;
  logic                       accept;
  logic                       out_free;
  logic                       full;
  logic                       empty;
  logic                       ok;
  logic                       do_ins;
  logic                       do_rem;
  logic                       do_rd;
  logic [ibl_pkg::POS_W-1:0]  op_pos;
  ibl_pkg::cell_ctl_t         ctl;

  logic [ibl_pkg::LEN_W-1:0]  count;
  logic [ibl_pkg::LEN_W-1:0]  count_next;
  logic                       s1_valid;
  logic                       s1_ok;
  logic [ibl_pkg::LEN_W-1:0]  s1_len;
  logic [ibl_pkg::BYTE_W-1:0] read_or;

  logic [ibl_pkg::BYTE_W-1:0] cell_data [N];
  logic [ibl_pkg::BYTE_W-1:0] cell_tap  [N];

  assign cmd   = s_tdata[2:0];
  assign pos   = s_tdata[9:3];
  assign value = s_tdata[17:10];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || out_free;
  assign accept   = s_tvalid && s_tready;

  assign full  = (count == ibl_pkg::LEN_W'(N));
  assign empty = (count == '0);

  always_comb begin
    ok     = 1'b0;
    do_ins = 1'b0;
    do_rem = 1'b0;
    do_rd  = 1'b0;
    op_pos = pos;
    case (cmd)
      ibl_pkg::CMD_APPEND: begin
        ok     = !full;
        do_ins = 1'b1;
        op_pos = count;
      end
      ibl_pkg::CMD_INSERT_AT: begin
        ok     = !full && (pos <= count);
        do_ins = 1'b1;
      end
      ibl_pkg::CMD_REMOVE_AT: begin
        ok     = (pos < count);
        do_rem = 1'b1;
      end
      ibl_pkg::CMD_REMOVE_FIRST: begin
        ok     = !empty;
        do_rem = 1'b1;
        op_pos = '0;
      end
      ibl_pkg::CMD_REMOVE_LAST: begin
        ok     = !empty;
        do_rem = 1'b1;
        op_pos = count - ibl_pkg::LEN_W'(1);
      end
      ibl_pkg::CMD_READ_AT: begin
        ok    = (pos < count);
        do_rd = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctl.acc   = accept;
    ctl.ins   = accept && ok && do_ins;
    ctl.rem   = accept && ok && do_rem;
    ctl.rd    = accept && ok && do_rd;
    ctl.pos   = op_pos;
    ctl.value = value;
  end

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + ibl_pkg::LEN_W'(1);
    end else if (ctl.rem) begin
      count_next = count - ibl_pkg::LEN_W'(1);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [ibl_pkg::BYTE_W-1:0] left_d;
    logic [ibl_pkg::BYTE_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end
    ibl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_index (ibl_pkg::IDX_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  always_comb begin
    read_or = '0;
    for (int i = 0; i < N; i++) begin
      read_or = read_or | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok  <= ok;
      s1_len <= count_next;
    end
    if (out_free && s1_valid) begin
      m_tdata <= {read_or, s1_len, s1_ok};
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ibl_pkg::LEN_W'(N))
    else $error("element count exceeds capacity");

  a_read_needs_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[15:8] != '0) |-> m_tdata[0])
    else $error("nonzero read byte on a failed item");

  a_full_append: assert property (@(posedge clk) disable iff (rst)
    accept && full && (cmd == ibl_pkg::CMD_APPEND) |=> $stable(count))
    else $error("append changed the count of a full list");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_len))
    else $error("middle stage lost an item while the output was stalled");
`endif

endmodule
`default_nettype wire
